>>> hw/rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

   localparam int DEPTH = 512;
   localparam int WEIGHT_BITS = 32;
   localparam int TAG_BITS = 16;
   localparam int IDX_BITS = $clog2(DEPTH);
   localparam int COUNT_BITS = $clog2(DEPTH + 1);
   localparam int ENTRY_COUNT_BITS = 10;

   typedef logic [WEIGHT_BITS-1:0] weight_type;
   typedef logic [TAG_BITS-1:0] tag_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [IDX_BITS-1:0] idx_type;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_POP    = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_QUERY  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK          = 2'd0,
      STAT_POP_EMPTY   = 2'd1,
      STAT_INSERT_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_SHIFT  = 2'd2
   } cell_op_type;

   // Broadcast from the controller to every cell of the chain.
   typedef struct packed {
      cell_op_type op;
      weight_type  weight;
      tag_type     tag;
      logic        tie_after_equal;
      count_type   count;
   } cell_ctrl_type;

endpackage

>>> hw/rtl/spq_cell.sv
// One slot of the sorted chain: holds a weight and tag and trades with its neighbors.
`timescale 1ns / 1ps

module spq_cell
   import spq_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  idx_type       idx,
   input  logic          left_gt,
   input  weight_type    left_weight,
   input  tag_type       left_tag,
   input  weight_type    right_weight,
   input  tag_type       right_tag,
   output logic          gt,
   output weight_type    weight,
   output tag_type       tag,
   output weight_type    weight_next,
   output tag_type       tag_next
);

   weight_type weight_ff, weight_in;
   tag_type    tag_ff, tag_in;
   logic       occupied;

   // Slots at or beyond the fill level count as larger than any new weight.
   assign occupied = count_type'(idx) < ctrl.count;

   always_comb begin
      if (!occupied) begin
         gt = 1'b1;
      end else if (ctrl.tie_after_equal) begin
         gt = weight_ff > ctrl.weight;
      end else begin
         gt = weight_ff >= ctrl.weight;
      end
   end

   always_comb begin
      weight_in = weight_ff;
      tag_in = tag_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            // The first slot with gt set takes the new entry; later ones move right.
            if (gt) begin
               if (left_gt) begin
                  weight_in = left_weight;
                  tag_in = left_tag;
               end else begin
                  weight_in = ctrl.weight;
                  tag_in = ctrl.tag;
               end
            end
         end
         CELL_SHIFT: begin
            weight_in = right_weight;
            tag_in = right_tag;
         end
         default: begin
            weight_in = weight_ff;
            tag_in = tag_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      weight_ff <= weight_in;
      tag_ff <= tag_in;
   end

   assign weight = weight_ff;
   assign tag = tag_ff;
   assign weight_next = weight_in;
   assign tag_next = tag_in;

endmodule

>>> hw/rtl/spq_chain.sv
// Row of sorted cells, head at slot zero.
`timescale 1ns / 1ps

module spq_chain
   import spq_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   output weight_type    head_weight_next,
   output tag_type       head_tag_next
);

   logic       gt_w [DEPTH];
   weight_type weight_w [DEPTH];
   tag_type    tag_w [DEPTH];
   weight_type weight_next_w [DEPTH];
   tag_type    tag_next_w [DEPTH];

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic       left_gt;
         weight_type left_weight, right_weight;
         tag_type    left_tag, right_tag;

         if (i == 0) begin : g_first
            assign left_gt = 1'b0;
            assign left_weight = '0;
            assign left_tag = '0;
         end else begin : g_mid
            assign left_gt = gt_w[i-1];
            assign left_weight = weight_w[i-1];
            assign left_tag = tag_w[i-1];
         end

         // The last slot shifts in a value that the lowered fill level hides.
         if (i == DEPTH - 1) begin : g_last
            assign right_weight = '0;
            assign right_tag = '0;
         end else begin : g_inner
            assign right_weight = weight_w[i+1];
            assign right_tag = tag_w[i+1];
         end

         spq_cell u_cell (
            .clock        (clock),
            .ctrl         (ctrl),
            .idx          (idx_type'(i)),
            .left_gt      (left_gt),
            .left_weight  (left_weight),
            .left_tag     (left_tag),
            .right_weight (right_weight),
            .right_tag    (right_tag),
            .gt           (gt_w[i]),
            .weight       (weight_w[i]),
            .tag          (tag_w[i]),
            .weight_next  (weight_next_w[i]),
            .tag_next     (tag_next_w[i])
         );
      end
   endgenerate

   assign head_weight_next = weight_next_w[0];
   assign head_tag_next = tag_next_w[0];

endmodule

>>> hw/rtl/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: controller, fill count and result register.
//
//   channel | direction | transfer when            | payload
//   req     | in        | req_valid && req_ready   | action, weight, tag, tie_after_equal
//   rsp     | out       | rsp_valid && rsp_ready   | head_weight, head_tag, is_empty,
//           |           |                          | entry_count, status
//
// All cells act together: on an insert they compare the new weight and shift, on a pop
// they shift left, and the result is in the output register on the next cycle.
// A new request transfers in every cycle while the result register is free or drained.
// A stalled result holds req_ready low; the chain itself never stalls.
// Reset clears the fill count and the result valid flag; slot contents need no reset.
`timescale 1ns / 1ps

module sorted_priority_queue_top
   import spq_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_action,
   input  logic [WEIGHT_BITS-1:0]      req_weight,
   input  logic [TAG_BITS-1:0]         req_tag,
   input  logic                        req_tie_after_equal,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [WEIGHT_BITS-1:0]      rsp_head_weight,
   output logic [TAG_BITS-1:0]         rsp_head_tag,
   output logic                        rsp_is_empty,
   output logic [ENTRY_COUNT_BITS-1:0] rsp_entry_count,
   output logic [1:0]                  rsp_status
);

   count_type     count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   weight_type    rsp_weight_ff, rsp_weight_in;
   tag_type       rsp_tag_ff, rsp_tag_in;
   logic          rsp_empty_ff, rsp_empty_in;
   count_type     rsp_count_ff, rsp_count_in;
   status_type    rsp_status_ff, rsp_status_in;
   cell_ctrl_type ctrl;
   action_type    action;
   logic          accept;
   weight_type    head_weight_next;
   tag_type       head_tag_next;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;
   assign action = action_type'(req_action);

   always_comb begin
      ctrl.op = CELL_HOLD;
      ctrl.weight = req_weight;
      ctrl.tag = req_tag;
      ctrl.tie_after_equal = req_tie_after_equal;
      ctrl.count = count_ff;
      count_in = count_ff;
      rsp_status_in = STAT_OK;
      if (accept) begin
         case (action)
            ACT_INSERT: begin
               if (count_ff == count_type'(DEPTH)) begin
                  rsp_status_in = STAT_INSERT_FULL;
               end else begin
                  ctrl.op = CELL_INSERT;
                  count_in = count_ff + count_type'(1);
               end
            end
            ACT_POP: begin
               if (count_ff == '0) begin
                  rsp_status_in = STAT_POP_EMPTY;
               end else begin
                  ctrl.op = CELL_SHIFT;
                  count_in = count_ff - count_type'(1);
               end
            end
            ACT_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   spq_chain u_chain (
      .clock            (clock),
      .ctrl             (ctrl),
      .head_weight_next (head_weight_next),
      .head_tag_next    (head_tag_next)
   );

   always_comb begin
      rsp_empty_in = count_in == '0;
      rsp_count_in = count_in;
      rsp_weight_in = rsp_empty_in ? '0 : head_weight_next;
      rsp_tag_in = rsp_empty_in ? '0 : head_tag_next;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_weight_ff <= rsp_weight_in;
         rsp_tag_ff <= rsp_tag_in;
         rsp_empty_ff <= rsp_empty_in;
         rsp_count_ff <= rsp_count_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_head_weight = rsp_weight_ff;
   assign rsp_head_tag = rsp_tag_ff;
   assign rsp_is_empty = rsp_empty_ff;
   assign rsp_entry_count = ENTRY_COUNT_BITS'(rsp_count_ff);
   assign rsp_status = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= count_type'(DEPTH))
      else $error("fill count exceeds depth");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      accept && action == ACT_INSERT && count_ff == count_type'(DEPTH)
      |=> rsp_status_ff == STAT_INSERT_FULL && count_ff == count_type'(DEPTH))
      else $error("insert on full queue not dropped");

   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      accept && action == ACT_POP && count_ff == '0
      |=> rsp_status_ff == STAT_POP_EMPTY && rsp_empty_ff)
      else $error("pop on empty queue not flagged");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_empty_ff |-> rsp_weight_ff == '0 && rsp_tag_ff == '0)
      else $error("empty result carries a head entry");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff && rsp_count_ff == count_ff)
      else $error("result missing or count mismatch after transfer");

endmodule
